// ===== src/clock_alarm_digit_setter_top_assert.svh =====
// Assertion macros for the clock alarm digit setter RTL.
`ifndef CLOCK_ALARM_DIGIT_SETTER_TOP_ASSERT_SVH
`define CLOCK_ALARM_DIGIT_SETTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define CADS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("digit setter check failed");
// The consequent must hold in the cycle after the antecedent.
`define CADS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("digit setter check failed");
`else
`define CADS_ASSERT_SAME(label, clk, rst, ante, cons)
`define CADS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/cads_pkg.sv =====
// Types and constants of the clock alarm digit setter.
`default_nettype none
package cads_pkg;

  typedef logic [3:0] digit_t;
  typedef digit_t [0:5] time_digits_t;
  typedef digit_t [0:3] alarm_digits_t;

  localparam logic [1:0] MODE_RUN       = 2'd0;
  localparam logic [1:0] MODE_SET_TIME  = 2'd1;
  localparam logic [1:0] MODE_SET_ALARM = 2'd2;

  localparam logic [2:0] CURSOR_FIRST = 3'd0;
  localparam logic [2:0] CURSOR_LAST  = 3'd5;
  localparam logic [2:0] TIME_DIGITS  = 3'd6;
  localparam logic [2:0] ALARM_DIGITS = 3'd4;

  localparam digit_t HOUR_TENS_MAX     = 4'd2;
  localparam digit_t HOUR_UNITS_TOP    = 4'd3;
  localparam digit_t TENS_MAX          = 4'd5;
  localparam digit_t UNITS_MAX         = 4'd9;

  typedef struct packed {
    logic inc_press;
    logic mode_press;
    logic dec_press;
    logic right_press;
    logic left_press;
  } scan_word_t;

  typedef struct packed {
    logic [1:0]  mode_now;
    logic [2:0]  cursor_now;
    logic        clock_run;
    logic [23:0] time_bcd;
    logic [15:0] alarm_bcd;
  } status_word_t;

  typedef struct packed {
    logic [1:0]    mode;
    logic [2:0]    cursor;
    logic          run;
    time_digits_t  time_digits;
    alarm_digits_t alarm_digits;
  } state_t;

endpackage
`default_nettype wire

// ===== src/cads_step.sv =====
// Next-state logic for one button scan: digit edits, mode cycling and cursor moves.
`default_nettype none
module cads_step (
  input  wire cads_pkg::state_t     cur,
  input  wire cads_pkg::scan_word_t word,
  output cads_pkg::state_t          nxt
);

  // Raise one digit within the 24-hour limits; positions at or past ndig are left alone.
  function automatic cads_pkg::time_digits_t bump(input cads_pkg::time_digits_t d,
                                                  input logic [2:0] pos,
                                                  input logic [2:0] ndig);
    cads_pkg::time_digits_t r;
    cads_pkg::digit_t       lim;
    r   = d;
    lim = cads_pkg::UNITS_MAX;
    if (pos < ndig) begin
      if (pos == 3'd0) begin
        // Moving hour tens from 1 to 2 pulls a large hour units digit down to 3.
        if (d[0] == 4'd1 && d[1] > cads_pkg::HOUR_UNITS_TOP) begin
          r[1] = cads_pkg::HOUR_UNITS_TOP;
          r[0] = cads_pkg::HOUR_TENS_MAX;
        end else if (d[0] < cads_pkg::HOUR_TENS_MAX) begin
          r[0] = d[0] + 4'd1;
        end
      end else begin
        if (pos == 3'd1) begin
          lim = (d[0] == cads_pkg::HOUR_TENS_MAX) ? cads_pkg::HOUR_UNITS_TOP
                                                   : cads_pkg::UNITS_MAX;
        end else if (pos == 3'd2 || pos == 3'd4) begin
          lim = cads_pkg::TENS_MAX;
        end
        if (d[pos] < lim) begin
          r[pos] = d[pos] + 4'd1;
        end
      end
    end
    return r;
  endfunction

  function automatic cads_pkg::time_digits_t drop(input cads_pkg::time_digits_t d,
                                                  input logic [2:0] pos,
                                                  input logic [2:0] ndig);
    cads_pkg::time_digits_t r;
    r = d;
    if (pos < ndig && d[pos] != 4'd0) begin
      r[pos] = d[pos] - 4'd1;
    end
    return r;
  endfunction

  cads_pkg::time_digits_t t;
  cads_pkg::time_digits_t a;
  logic [1:0]             m;
  logic                   r;
  logic [2:0]             c;

  // The alarm uses the upper four of six digit slots, so one editor serves both stores.
  always_comb begin
    t = cur.time_digits;
    a = {cur.alarm_digits, 8'h00};
    m = cur.mode;
    r = cur.run;
    c = cur.cursor;

    if (word.inc_press) begin
      if (m == cads_pkg::MODE_SET_TIME) begin
        t = bump(t, c, cads_pkg::TIME_DIGITS);
      end else if (m == cads_pkg::MODE_SET_ALARM) begin
        a = bump(a, c, cads_pkg::ALARM_DIGITS);
      end
    end

    if (word.mode_press) begin
      if (m < cads_pkg::MODE_SET_ALARM) begin
        m = m + 2'd1;
        r = 1'b0;
      end else begin
        m = cads_pkg::MODE_RUN;
        r = 1'b1;
      end
    end

    // Decrement sees the mode as it stands after a mode press in the same scan.
    if (word.dec_press) begin
      if (m == cads_pkg::MODE_SET_TIME) begin
        t = drop(t, c, cads_pkg::TIME_DIGITS);
      end else if (m == cads_pkg::MODE_SET_ALARM) begin
        a = drop(a, c, cads_pkg::ALARM_DIGITS);
      end
    end

    if (word.right_press && c < cads_pkg::CURSOR_LAST) begin
      c = c + 3'd1;
    end
    if (word.left_press && c != cads_pkg::CURSOR_FIRST) begin
      c = c - 3'd1;
    end

    nxt.mode         = m;
    nxt.cursor       = c;
    nxt.run          = r;
    nxt.time_digits  = t;
    nxt.alarm_digits = a[0:3];
  end

endmodule
`default_nettype wire

// ===== src/clock_alarm_digit_setter_top.sv =====
// Top level of the clock alarm digit setter: scan register, edit logic and status register.
// The block takes one button scan word per cycle while scan_ready is high and returns one
// status word per scan, reporting mode, cursor, run enable and the packed time and alarm
// digits after that scan. A scan word is held in an input register, passes the edit logic
// and lands in the status register when that register is free or being emptied, where
// its status word is offered. The edit state updates as a word leaves the input register,
// so the throughput is one word per cycle, limited only by the status port's ready.
`default_nettype none
`include "clock_alarm_digit_setter_top_assert.svh"
module clock_alarm_digit_setter_top (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         scan_valid,
  output logic                        scan_ready,
  input  wire cads_pkg::scan_word_t   scan_word,
  output logic                        status_valid,
  input  wire                         status_ready,
  output cads_pkg::status_word_t      status_word
);

  logic                 hold_valid;
  cads_pkg::scan_word_t hold_word;
  cads_pkg::state_t     state;
  cads_pkg::state_t     state_next;
  logic                 advance;

  // A held word moves on whenever the status register is free or being emptied.
  assign advance    = hold_valid && (!status_valid || status_ready);
  assign scan_ready = !hold_valid || advance;

  cads_step u_step (
    .cur  (state),
    .word (hold_word),
    .nxt  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid          <= 1'b0;
      status_valid        <= 1'b0;
      state.mode          <= cads_pkg::MODE_RUN;
      state.cursor        <= cads_pkg::CURSOR_FIRST;
      state.run           <= 1'b1;
      state.time_digits   <= '0;
      state.alarm_digits  <= '0;
    end else begin
      if (scan_ready) begin
        hold_valid <= scan_valid;
      end
      if (advance) begin
        state        <= state_next;
        status_valid <= 1'b1;
      end else if (status_ready) begin
        status_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_valid && scan_ready) begin
      hold_word <= scan_word;
    end
    if (advance) begin
      status_word.mode_now   <= state_next.mode;
      status_word.cursor_now <= state_next.cursor;
      status_word.clock_run  <= state_next.run;
      status_word.time_bcd   <= state_next.time_digits;
      status_word.alarm_bcd  <= state_next.alarm_digits;
    end
  end

  `CADS_ASSERT_SAME(a_run_follows_mode, clk, rst, 1'b1,
                    state.run == (state.mode == cads_pkg::MODE_RUN))
  `CADS_ASSERT_SAME(a_cursor_in_range, clk, rst, 1'b1, state.cursor <= cads_pkg::CURSOR_LAST)
  `CADS_ASSERT_NEXT(a_state_only_on_advance, clk, rst, !advance, $stable(state))
  `CADS_ASSERT_NEXT(a_stalled_word_kept, clk, rst,
                    hold_valid && status_valid && !status_ready, hold_valid && $stable(hold_word))

endmodule
`default_nettype wire
